// ===== src/egu_pkg.sv =====
// ----------------------------------------------------------------------------
// Event flag group package
// Shared widths, action, kind and status codes, and the wait record type.
// ----------------------------------------------------------------------------
package egu_pkg;

    localparam int TASKS    = 8;
    localparam int SLOT_W   = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int FLAG_W   = 32;
    localparam int ACTION_W = 2;
    localparam int TASK_W   = 3;
    localparam int BIT_W    = 5;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int GUARD_W  = 4;

    localparam logic [GUARD_W-1:0] GUARD_RESET = 4'd8;

    localparam logic [ACTION_W-1:0] ACT_WAIT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SET    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLR    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_RESUME = 2'd3;

    localparam logic [KIND_W-1:0] KIND_OUTCOME = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WAKE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FAIL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_PEND = 2'd2;

    typedef struct packed {
        logic [FLAG_W-1:0] mask;
        logic              all;
        logic              consume;
    } t_wait_rec;

endpackage

// ===== src/egu_in_if.sv =====
// ----------------------------------------------------------------------------
// Event flag group request channel
// Valid/ready channel that carries one request transaction.
// ----------------------------------------------------------------------------
interface egu_in_if;
    logic                          valid;
    logic                          ready;
    logic [egu_pkg::ACTION_W-1:0]  action;
    logic [egu_pkg::TASK_W-1:0]    task_index;
    logic [egu_pkg::FLAG_W-1:0]    care_mask;
    logic                          match_all;
    logic                          consume;
    logic                          may_block;
    logic [egu_pkg::BIT_W-1:0]     bit_index;

    modport source (
        output valid, action, task_index, care_mask, match_all, consume,
               may_block, bit_index,
        input  ready
    );
    modport sink (
        input  valid, action, task_index, care_mask, match_all, consume,
               may_block, bit_index,
        output ready
    );
endinterface

// ===== src/egu_out_if.sv =====
// ----------------------------------------------------------------------------
// Event flag group result channel
// Valid/ready channel that carries one result transaction.
// ----------------------------------------------------------------------------
interface egu_out_if;
    logic                          valid;
    logic                          ready;
    logic [egu_pkg::KIND_W-1:0]    kind;
    logic [egu_pkg::TASK_W-1:0]    task_index_out;
    logic [egu_pkg::STATUS_W-1:0]  status;
    logic [egu_pkg::FLAG_W-1:0]    flags_now;
    logic                          last;

    modport source (
        output valid, kind, task_index_out, status, flags_now, last,
        input  ready
    );
    modport sink (
        input  valid, kind, task_index_out, status, flags_now, last,
        output ready
    );
endinterface

// ===== src/egu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module egu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/egu_match.sv =====
// ----------------------------------------------------------------------------
// Event flag group match unit
// Tests a wait condition against the flag word and forms the consumed word.
// ----------------------------------------------------------------------------
module egu_match (
    input  logic [egu_pkg::FLAG_W-1:0] i_flags,
    input  egu_pkg::t_wait_rec         i_rec,
    output logic                       o_holds,
    output logic [egu_pkg::FLAG_W-1:0] o_consumed
);
    import egu_pkg::*;

    logic [FLAG_W-1:0] hit;

    assign hit        = i_flags & i_rec.mask;
    assign o_holds    = i_rec.all ? (hit == i_rec.mask) : (hit != '0);
    assign o_consumed = i_flags & ~i_rec.mask;
endmodule

// ===== src/event_flag_group_unit.sv =====
// ----------------------------------------------------------------------------
// Event flag group unit
// A wait or resume gives a registered result from the EXEC state once the
// output can take it. A set or clear scans every task slot, one per cycle
// unless an output stall holds a wake result, then gives a done result. A
// new request is accepted once the previous one has its last result queued.
// Synchronous active-low reset clears flags, blocked marks and record marks.
// ----------------------------------------------------------------------------
module event_flag_group_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [egu_pkg::GUARD_W-1:0] i_cfg_wdata,
    egu_in_if.sink                      i_in,
    egu_out_if.source                   o_out
);
    import egu_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [FLAG_W-1:0]   r_flags, n_flags;
    logic [GUARD_W-1:0]  r_guard;
    logic [TASKS-1:0]    r_blocked, n_blocked;
    logic [TASKS-1:0]    r_rec_valid, n_rec_valid;
    logic                r_rd_valid;

    logic [ACTION_W-1:0] r_action;
    logic [TASK_W-1:0]   r_task;
    t_wait_rec           r_req;
    logic                r_may_block;

    logic                r_out_valid, n_out_valid;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [TASK_W-1:0]   r_otask, n_otask;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [FLAG_W-1:0]   r_oflags, n_oflags;
    logic                r_last, n_last;

    logic                accept;
    logic                can_emit;
    logic                ram_we;
    logic                ram_re;
    logic [SLOT_W-1:0]   ram_raddr;
    logic [SLOT_W-1:0]   task_slot;
    t_wait_rec           ram_rdata;
    t_wait_rec           rec;
    t_wait_rec           m_rec;
    logic                m_holds;
    logic [FLAG_W-1:0]   m_consumed;
    logic                wake;

    assign accept    = i_in.valid && i_in.ready;
    assign can_emit  = !r_out_valid || o_out.ready;
    assign task_slot = SLOT_W'(r_task);
    assign rec       = r_rd_valid ? ram_rdata : '0;
    assign m_rec     = (r_state == S_EXEC && r_action == ACT_WAIT) ? r_req : rec;
    assign wake      = r_blocked[r_slot] && (32'(r_slot) != 32'(r_guard)) && m_holds;

    assign i_in.ready = (r_state == S_IDLE);

    egu_match u_match (
        .i_flags    (r_flags),
        .i_rec      (m_rec),
        .o_holds    (m_holds),
        .o_consumed (m_consumed)
    );

    egu_ram #(
        .WIDTH ($bits(t_wait_rec)),
        .DEPTH (TASKS)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (task_slot),
        .i_wdata (r_req),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_flags     = r_flags;
        n_blocked   = r_blocked;
        n_rec_valid = r_rec_valid;
        n_out_valid = r_out_valid && !o_out.ready;
        n_kind      = r_kind;
        n_otask     = r_otask;
        n_status    = r_status;
        n_oflags    = r_oflags;
        n_last      = r_last;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    ram_re = 1'b1;
                    if (i_in.action inside {ACT_SET, ACT_CLR}) begin
                        if (i_in.action == ACT_SET) begin
                            n_flags = r_flags | (FLAG_W'(1) << i_in.bit_index);
                        end else begin
                            n_flags = r_flags & ~(FLAG_W'(1) << i_in.bit_index);
                        end
                        n_slot  = '0;
                        n_state = S_SCAN;
                    end else begin
                        ram_raddr = SLOT_W'(i_in.task_index);
                        n_state   = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_OUTCOME;
                    n_otask     = r_task;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                    if (32'(r_task) >= TASKS) begin
                        n_status = STAT_FAIL;
                    end else if (r_action == ACT_WAIT) begin
                        if (m_holds) begin
                            n_status = STAT_OK;
                            if (r_req.consume) begin
                                n_flags = m_consumed;
                            end
                        end else if (r_may_block) begin
                            n_status               = STAT_PEND;
                            ram_we                 = 1'b1;
                            n_rec_valid[task_slot] = 1'b1;
                            n_blocked[task_slot]   = 1'b1;
                        end else begin
                            n_status = STAT_FAIL;
                        end
                    end else begin
                        n_blocked[task_slot] = 1'b0;
                        if (m_holds) begin
                            n_status = STAT_OK;
                            if (rec.consume) begin
                                n_flags = m_consumed;
                            end
                        end else begin
                            n_status = STAT_FAIL;
                        end
                    end
                    n_oflags = n_flags;
                end
            end
            S_SCAN: begin
                if (!wake || can_emit) begin
                    if (wake) begin
                        n_blocked[r_slot] = 1'b0;
                        n_out_valid       = 1'b1;
                        n_kind            = KIND_WAKE;
                        n_otask           = TASK_W'(r_slot);
                        n_status          = STAT_OK;
                        n_oflags          = r_flags;
                        n_last            = 1'b0;
                    end
                    if (r_slot == SLOT_W'(TASKS - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_slot    = r_slot + SLOT_W'(1);
                        ram_re    = 1'b1;
                        ram_raddr = r_slot + SLOT_W'(1);
                    end
                end
            end
            S_DONE: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_DONE;
                    n_otask     = '0;
                    n_status    = STAT_OK;
                    n_oflags    = r_flags;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_flags     <= '0;
            r_guard     <= GUARD_RESET;
            r_blocked   <= '0;
            r_rec_valid <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_flags     <= n_flags;
            r_blocked   <= n_blocked;
            r_rec_valid <= n_rec_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_guard <= i_cfg_wdata;
            end
            if (ram_re) begin
                r_rd_valid <= r_rec_valid[ram_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_otask  <= n_otask;
        r_status <= n_status;
        r_oflags <= n_oflags;
        r_last   <= n_last;
        if (accept) begin
            r_action    <= i_in.action;
            r_task      <= i_in.task_index;
            r_req       <= '{mask: i_in.care_mask, all: i_in.match_all,
                             consume: i_in.consume};
            r_may_block <= i_in.may_block;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_kind;
    assign o_out.task_index_out = r_otask;
    assign o_out.status         = r_status;
    assign o_out.flags_now      = r_oflags;
    assign o_out.last           = r_last;
endmodule

// ===== verif/tb_event_flag_group_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Event flag group unit testbench
// Walks a directed stimulus table, then runs random request phases under
// several guard task settings. Every result is checked field by field against
// an in-bench flag and wait record model; typed rows set status and flags.
// ----------------------------------------------------------------------------
module tb_event_flag_group_unit;
    import egu_pkg::*;

    localparam int LIMIT_CYCLES   = 300000;
    localparam int RANDOM_PHASES  = 4;
    localparam int ITEMS_PER_PHASE = 27;
    localparam int DIR_ROWS       = 24;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TASK_W-1:0]   slot;
        logic [FLAG_W-1:0]   mask;
        logic                all_bits;
        logic                consume;
        logic                may_block;
        logic [BIT_W-1:0]    bit_idx;
    } t_request;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [TASK_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
        logic [FLAG_W-1:0]   flags;
        logic                last;
    } t_result;

    typedef struct packed {
        logic                is_cfg;
        logic [GUARD_W-1:0]  guard;
        t_request            req;
        logic                typed;
        logic [STATUS_W-1:0] t_status;
        logic [FLAG_W-1:0]   t_flags;
    } t_stim_row;

    localparam t_request NO_REQ = '{ACT_WAIT, 3'd0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0};

    localparam t_stim_row DIR_TABLE [0:DIR_ROWS-1] = '{
        '{1'b0, 4'd0, '{ACT_WAIT, 3'd0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0},
          1'b1, STAT_FAIL, 32'h0},
        '{1'b0, 4'd0, '{ACT_WAIT, 3'd1, 32'h0, 1'b1, 1'b0, 1'b0, 5'd0},
          1'b1, STAT_OK, 32'h0},
        '{1'b0, 4'd0, '{ACT_WAIT, 3'd2, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 5'd0},
          1'b1, STAT_PEND, 32'h0},
        '{1'b0, 4'd0, '{ACT_WAIT, 3'd3, 32'h1, 1'b0, 1'b0, 1'b1, 5'd0},
          1'b1, STAT_PEND, 32'h0},
        '{1'b0, 4'd0, '{ACT_RESUME, 3'd4, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0},
          1'b1, STAT_FAIL, 32'h0},
        '{1'b0, 4'd0, '{ACT_SET, 3'd0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0},
          1'b0, STAT_OK, 32'h0},
        '{1'b0, 4'd0, '{ACT_SET, 3'd5, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 5'd31},
          1'b0, STAT_OK, 32'h0},
        '{1'b0, 4'd0, '{ACT_CLR, 3'd7, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0},
          1'b0, STAT_OK, 32'h0},
        '{1'b0, 4'd0, '{ACT_RESUME, 3'd3, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0},
          1'b1, STAT_FAIL, 32'h8000_0000},
        '{1'b0, 4'd0, '{ACT_WAIT, 3'd5, 32'h8000_0000, 1'b1, 1'b1, 1'b0, 5'd0},
          1'b1, STAT_OK, 32'h0},
        '{1'b0, 4'd0, '{ACT_WAIT, 3'd6, 32'h0001_0000, 1'b0, 1'b1, 1'b1, 5'd0},
          1'b1, STAT_PEND, 32'h0},
        '{1'b0, 4'd0, '{ACT_WAIT, 3'd7, 32'h0001_0000, 1'b0, 1'b0, 1'b1, 5'd0},
          1'b1, STAT_PEND, 32'h0},
        '{1'b0, 4'd0, '{ACT_SET, 3'd0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd16},
          1'b0, STAT_OK, 32'h0},
        '{1'b0, 4'd0, '{ACT_RESUME, 3'd6, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0},
          1'b1, STAT_OK, 32'h0},
        '{1'b0, 4'd0, '{ACT_RESUME, 3'd7, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0},
          1'b1, STAT_FAIL, 32'h0},
        '{1'b1, 4'd0, NO_REQ, 1'b0, STAT_OK, 32'h0},
        '{1'b0, 4'd0, '{ACT_WAIT, 3'd0, 32'h20, 1'b1, 1'b0, 1'b1, 5'd0},
          1'b1, STAT_PEND, 32'h0},
        '{1'b0, 4'd0, '{ACT_SET, 3'd0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd5},
          1'b0, STAT_OK, 32'h0},
        '{1'b0, 4'd0, '{ACT_RESUME, 3'd0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0},
          1'b1, STAT_OK, 32'h20},
        '{1'b1, 4'd7, NO_REQ, 1'b0, STAT_OK, 32'h0},
        '{1'b0, 4'd0, '{ACT_WAIT, 3'd7, 32'h40, 1'b0, 1'b0, 1'b1, 5'd0},
          1'b1, STAT_PEND, 32'h20},
        '{1'b0, 4'd0, '{ACT_SET, 3'd0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd6},
          1'b0, STAT_OK, 32'h0},
        '{1'b0, 4'd0, '{ACT_CLR, 3'd0, 32'h0, 1'b0, 1'b0, 1'b0, 5'd5},
          1'b0, STAT_OK, 32'h0},
        '{1'b0, 4'd0, '{ACT_RESUME, 3'd7, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0},
          1'b1, STAT_OK, 32'h40}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [GUARD_W-1:0] i_cfg_wdata;

    egu_in_if  in_ch ();
    egu_out_if out_ch ();

    event_flag_group_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    logic [FLAG_W-1:0]  model_flags = '0;
    logic [FLAG_W-1:0]  model_mask [TASKS] = '{default: '0};
    logic               model_all [TASKS] = '{default: 1'b0};
    logic               model_consume [TASKS] = '{default: 1'b0};
    logic               model_blocked [TASKS] = '{default: 1'b0};
    logic [GUARD_W-1:0] model_guard = GUARD_RESET;

    t_result pending_results [$];
    int      mismatches  = 0;
    int      burst_left  = 0;
    int      cycle_count = 0;
    logic [5:0] stall_timer = '0;
    logic [1:0] stall_mode  = '0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic condition_met(logic [FLAG_W-1:0] mask, logic all_bits);
        if (all_bits)
            return (model_flags & mask) == mask;
        return (model_flags & mask) != '0;
    endfunction

    task automatic push_result(logic [KIND_W-1:0] kind, int slot,
                               logic [STATUS_W-1:0] status, logic last);
        t_result res;
        res.kind   = kind;
        res.slot   = slot[TASK_W-1:0];
        res.status = status;
        res.flags  = model_flags;
        res.last   = last;
        pending_results.push_back(res);
    endtask

    task automatic apply_request(t_request r);
        int s;
        s = r.slot;
        case (r.action)
            ACT_SET, ACT_CLR: begin
                if (r.action == ACT_SET)
                    model_flags[r.bit_idx] = 1'b1;
                else
                    model_flags[r.bit_idx] = 1'b0;
                for (int i = 0; i < TASKS; i++) begin
                    if (model_blocked[i] && i != int'(model_guard) &&
                        condition_met(model_mask[i], model_all[i])) begin
                        model_blocked[i] = 1'b0;
                        push_result(KIND_WAKE, i, STAT_OK, 1'b0);
                    end
                end
                push_result(KIND_DONE, 0, STAT_OK, 1'b1);
            end
            ACT_WAIT: begin
                if (condition_met(r.mask, r.all_bits)) begin
                    if (r.consume)
                        model_flags &= ~r.mask;
                    push_result(KIND_OUTCOME, s, STAT_OK, 1'b1);
                end else if (r.may_block) begin
                    model_mask[s]    = r.mask;
                    model_all[s]     = r.all_bits;
                    model_consume[s] = r.consume;
                    model_blocked[s] = 1'b1;
                    push_result(KIND_OUTCOME, s, STAT_PEND, 1'b1);
                end else begin
                    push_result(KIND_OUTCOME, s, STAT_FAIL, 1'b1);
                end
            end
            default: begin
                model_blocked[s] = 1'b0;
                if (condition_met(model_mask[s], model_all[s])) begin
                    if (model_consume[s])
                        model_flags &= ~model_mask[s];
                    push_result(KIND_OUTCOME, s, STAT_OK, 1'b1);
                end else begin
                    push_result(KIND_OUTCOME, s, STAT_FAIL, 1'b1);
                end
            end
        endcase
    endtask

    task automatic send_request(t_request r, logic typed,
                                logic [STATUS_W-1:0] t_status, logic [FLAG_W-1:0] t_flags);
        t_result tail;
        in_ch.valid      <= 1'b1;
        in_ch.action     <= r.action;
        in_ch.task_index <= r.slot;
        in_ch.care_mask  <= r.mask;
        in_ch.match_all  <= r.all_bits;
        in_ch.consume    <= r.consume;
        in_ch.may_block  <= r.may_block;
        in_ch.bit_index  <= r.bit_idx;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        apply_request(r);
        if (typed) begin
            tail = pending_results.pop_back();
            tail.status = t_status;
            tail.flags  = t_flags;
            pending_results.push_back(tail);
        end
        burst_left--;
        if (burst_left <= 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic drain_block();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        burst_left = $urandom_range(1, 24);
    endtask

    task automatic write_guard(logic [GUARD_W-1:0] value);
        drain_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        model_guard = value;
    endtask

    function automatic logic [FLAG_W-1:0] hot_mask(int hot_base);
        logic [FLAG_W-1:0] m;
        m = '0;
        repeat ($urandom_range(1, 3))
            m[hot_base + $urandom_range(0, 3)] = 1'b1;
        return m;
    endfunction

    function automatic t_request random_request(int hot_base);
        t_request r;
        int pick;
        int sleepers [$];
        r.action    = ACT_WAIT;
        r.slot      = TASK_W'($urandom_range(0, TASKS - 1));
        r.mask      = $urandom;
        r.all_bits  = 1'($urandom_range(0, 1));
        r.consume   = 1'($urandom_range(0, 1));
        r.may_block = 1'($urandom_range(0, 1));
        r.bit_idx   = BIT_W'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            r.action = ACTION_W'($urandom_range(0, 3));
            return r;
        end
        if (pick < 47) begin
            r.action = ACT_WAIT;
            pick = $urandom_range(0, 19);
            if (pick == 0)
                r.mask = '0;
            else if (pick == 1)
                r.mask = '1;
            else
                r.mask = hot_mask(hot_base);
            r.may_block = ($urandom_range(0, 4) != 0);
        end else if (pick < 87) begin
            r.action = ($urandom_range(0, 9) < 6) ? ACT_SET : ACT_CLR;
            if ($urandom_range(0, 4) != 0)
                r.bit_idx = BIT_W'(hot_base + $urandom_range(0, 3));
        end else begin
            r.action = ACT_RESUME;
            for (int i = 0; i < TASKS; i++)
                if (model_blocked[i])
                    sleepers.push_back(i);
            if (sleepers.size() != 0 && $urandom_range(0, 3) != 0)
                r.slot = TASK_W'(sleepers[$urandom_range(0, sleepers.size() - 1)]);
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name,
                     expected, actual);
        end
    endtask

    always @(posedge i_clk) begin
        stall_timer <= stall_timer + 6'd1;
        if (stall_timer == 6'd0)
            stall_mode <= 2'($urandom_range(0, 2));
        case (stall_mode)
            2'd0:    out_ch.ready <= 1'b1;
            2'd1:    out_ch.ready <= 1'($urandom_range(0, 1));
            default: out_ch.ready <= (stall_timer[1:0] == 2'd3);
        endcase
    end

    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual kind %0d task %0d",
                         $time, out_ch.kind, out_ch.task_index_out);
            end else begin
                exp_res = pending_results.pop_front();
                check_field("kind", 32'(exp_res.kind), 32'(out_ch.kind));
                check_field("task_index_out", 32'(exp_res.slot), 32'(out_ch.task_index_out));
                check_field("status", 32'(exp_res.status), 32'(out_ch.status));
                check_field("flags_now", exp_res.flags, out_ch.flags_now);
                check_field("last", 32'(exp_res.last), 32'(out_ch.last));
            end
        end
    end

    initial begin
        t_stim_row row;
        int hot_base;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= GUARD_RESET;
        in_ch.valid      <= 1'b0;
        in_ch.action     <= ACT_WAIT;
        in_ch.task_index <= '0;
        in_ch.care_mask  <= '0;
        in_ch.match_all  <= 1'b0;
        in_ch.consume    <= 1'b0;
        in_ch.may_block  <= 1'b0;
        in_ch.bit_index  <= '0;
        burst_left = $urandom_range(1, 24);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            row = DIR_TABLE[k];
            if (row.is_cfg)
                write_guard(row.guard);
            else
                send_request(row.req, row.typed, row.t_status, row.t_flags);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       write_guard(GUARD_RESET);
                1:       write_guard(GUARD_W'(0));
                2:       write_guard(GUARD_W'(TASKS - 1));
                default: write_guard(GUARD_W'($urandom_range(0, TASKS)));
            endcase
            hot_base = $urandom_range(0, 28);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 39) == 0)
                    drain_block();
                send_request(random_request(hot_base), 1'b0, STAT_OK, '0);
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TASKS + 12) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            mismatches++;
            $display("%0t: %0d results missing", $time, pending_results.size());
        end
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
